>>> src/accalu_pkg.sv
// accalu_pkg: operation codes, status codes and fixed field widths
// for the accumulator calculator; depends on nothing
`default_nettype none

package accalu_pkg;

  // field widths of the input and result words
  localparam int OP_W   = 3;
  localparam int OPND_W = 32;
  localparam int ST_W   = 3;

  // operation codes
  localparam logic [OP_W-1:0] OP_SET = 3'd0;
  localparam logic [OP_W-1:0] OP_END = 3'd1;
  localparam logic [OP_W-1:0] OP_ADD = 3'd2;
  localparam logic [OP_W-1:0] OP_SUB = 3'd3;
  localparam logic [OP_W-1:0] OP_MUL = 3'd4;
  localparam logic [OP_W-1:0] OP_DIV = 3'd5;

  // status codes
  localparam logic [ST_W-1:0] ST_OK      = 3'd0;
  localparam logic [ST_W-1:0] ST_DIVZERO = 3'd1;
  localparam logic [ST_W-1:0] ST_UNKNOWN = 3'd2;
  localparam logic [ST_W-1:0] ST_SAT     = 3'd3;
  localparam logic [ST_W-1:0] ST_HALTED  = 3'd4;

endpackage

`default_nettype wire

>>> src/accalu_if.sv
// accalu_in_if and accalu_out_if: valid/ready channels for operation words
// and result words; depends on accalu_pkg
`default_nettype none

interface accalu_in_if import accalu_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          operation;
  logic signed [OPND_W-1:0] operand;

  modport source (output valid, output operation, output operand, input ready);
  modport sink   (input valid, input operation, input operand, output ready);
endinterface

interface accalu_out_if import accalu_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [OPND_W-1:0] acc_value;
  logic [ST_W-1:0]          status;
  logic                     ended;

  modport source (output valid, output acc_value, output status, output ended, input ready);
  modport sink   (input valid, input acc_value, input status, input ended, output ready);
endinterface

`default_nettype wire

>>> src/accalu_addsub.sv
// accalu_addsub: the shared adder/subtractor of the calculator, with carry out
// depends on nothing
`default_nettype none

module accalu_addsub #(
  parameter int W = 33
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic         sub,
  output logic [W:0]   y
);

  // a + b, or a - b as a + ~b + 1; y[W] is the carry (no borrow on subtract)
  assign y = {1'b0, a} + {1'b0, (sub ? ~b : b)} + (W + 1)'(sub);

endmodule

`default_nettype wire

>>> src/accumulator_alu_with_divide_check.sv
// accumulator_alu_with_divide_check: top level of the fixed-point accumulator
// calculator; depends on accalu_pkg, accalu_if and accalu_addsub
`default_nettype none

// Accumulator calculator on signed fixed point with FRAC_BITS fraction bits.
// Each input word carries an operation (set, end, add, subtract, multiply,
// divide) and a 32-bit signed operand; each one yields exactly one result word
// with the new accumulator (low 32 bits, sign extended when the accumulator is
// narrower), a status and an end mark. Results saturate to the DATA_WIDTH range.
// One word is worked on at a time and in_chan.ready is high only while idle.
// Set, end, add, subtract, unknown codes, divide by zero and any word after end
// go from accept straight to result hand-off. Multiply runs 32 shift-add
// steps over the operand bits on the one shared adder, between load and the
// sign fix before result hand-off. Divide makes one restoring quotient bit per
// cycle on the same adder, then the sign fix. The result register frees the
// sequencer as soon as the word is handed over; hand-off waits for it to be free.
module accumulator_alu_with_divide_check import accalu_pkg::*; #(
  parameter int FRAC_BITS  = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  accalu_in_if.sink   in_chan,
  accalu_out_if.source out_chan
);

  localparam int DW      = DATA_WIDTH;
  localparam int AW      = ((DW > OPND_W) ? DW : OPND_W) + 1;
  localparam int NW      = DW + FRAC_BITS;
  localparam int VW      = DW + OPND_W;
  localparam int CNT_TOP = (NW > OPND_W) ? NW : OPND_W;
  localparam int CW      = $clog2(CNT_TOP + 1);

  localparam logic [AW-1:0] MAX_A  = {{(AW - DW + 1){1'b0}}, {(DW - 1){1'b1}}};
  localparam logic [AW-1:0] MIN_A  = ~MAX_A;
  localparam logic [DW-1:0] MAX_D  = {1'b0, {(DW - 1){1'b1}}};
  localparam logic [DW-1:0] MIN_D  = {1'b1, {(DW - 1){1'b0}}};
  localparam logic [VW-1:0] LIM_V  = VW'(1) << (DW - 1);
  localparam logic [VW-1:0] LIMM_V = LIM_V - VW'(1);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_FIX  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [DW-1:0]     acc_r, acc_nxt;
  logic              halted_r, halted_nxt;
  logic [DW-1:0]     mcand_r, mcand_nxt;
  logic [DW-1:0]     mhi_r, mhi_nxt;
  logic [OPND_W-1:0] mlo_r, mlo_nxt;
  logic [NW-1:0]     nq_r, nq_nxt;
  logic [OPND_W-1:0] rem_r, rem_nxt;
  logic [OPND_W-1:0] dvs_r, dvs_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              neg_r, neg_nxt;
  logic              is_div_r, is_div_nxt;
  logic [ST_W-1:0]   res_status_r, res_status_nxt;
  logic              res_ended_r, res_ended_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [OPND_W-1:0] out_acc_r, out_acc_nxt;
  logic [ST_W-1:0]   out_status_r, out_status_nxt;
  logic              out_ended_r, out_ended_nxt;

  logic [AW-1:0]     alu_a, alu_b;
  logic              alu_sub;
  logic [AW:0]       alu_y;

  logic [AW-1:0]     acc_sx, opnd_sx, sum_s;
  logic [OPND_W-1:0] opnd_u, opnd_mag;
  logic [OP_W-1:0]   op;
  logic [OPND_W:0]   div_r2;
  logic [DW:0]       mul_s;
  logic [VW-1:0]     res_v;
  logic              fix_sat, out_free, in_fire;

  // operand views
  assign op       = in_chan.operation;
  assign opnd_u   = in_chan.operand;
  assign opnd_mag = opnd_u[OPND_W-1] ? (~opnd_u + OPND_W'(1)) : opnd_u;
  assign acc_sx   = {{(AW - DW){acc_r[DW-1]}}, acc_r};
  assign opnd_sx  = {{(AW - OPND_W){opnd_u[OPND_W-1]}}, opnd_u};
  assign in_fire  = in_chan.valid && in_chan.ready;
  assign out_free = !out_valid_r || out_chan.ready;

  // shared adder
  accalu_addsub #(.W(AW)) u_addsub (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .y   (alu_y)
  );

  assign sum_s  = alu_y[AW-1:0];
  assign div_r2 = {rem_r, nq_r[NW-1]};
  assign mul_s  = alu_y[DW:0];

  // magnitude of the multiply or divide result before sign and saturation
  assign res_v   = is_div_r ? VW'(nq_r) : VW'({mhi_r, mlo_r} >> FRAC_BITS);
  assign fix_sat = neg_r ? (res_v > LIM_V) : (res_v > LIMM_V);

  // adder operand select per state
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (op == OP_ADD || op == OP_SUB) begin
          alu_a   = acc_sx;
          alu_b   = opnd_sx;
          alu_sub = (op == OP_SUB);
        end else begin
          // magnitude of the accumulator
          alu_b   = acc_sx;
          alu_sub = acc_r[DW-1];
        end
      end
      S_MUL: begin
        alu_a = AW'(mhi_r);
        alu_b = mlo_r[0] ? AW'(mcand_r) : '0;
      end
      S_DIV: begin
        alu_a   = AW'(div_r2);
        alu_b   = AW'(dvs_r);
        alu_sub = 1'b1;
      end
      S_FIX: begin
        alu_b   = AW'(res_v[DW-1:0]);
        alu_sub = neg_r;
      end
      default: begin
        alu_sub = 1'b0;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    acc_nxt        = acc_r;
    halted_nxt     = halted_r;
    mcand_nxt      = mcand_r;
    mhi_nxt        = mhi_r;
    mlo_nxt        = mlo_r;
    nq_nxt         = nq_r;
    rem_nxt        = rem_r;
    dvs_nxt        = dvs_r;
    cnt_nxt        = cnt_r;
    neg_nxt        = neg_r;
    is_div_nxt     = is_div_r;
    res_status_nxt = res_status_r;
    res_ended_nxt  = res_ended_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_acc_nxt    = out_acc_r;
    out_status_nxt = out_status_r;
    out_ended_nxt  = out_ended_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          res_status_nxt = ST_OK;
          res_ended_nxt  = 1'b0;
          state_nxt      = S_FIN;
          if (halted_r) begin
            res_status_nxt = ST_HALTED;
          end else begin
            case (op)
              OP_SET: begin
                if ($signed(opnd_sx) > $signed(MAX_A)) begin
                  acc_nxt        = MAX_D;
                  res_status_nxt = ST_SAT;
                end else if ($signed(opnd_sx) < $signed(MIN_A)) begin
                  acc_nxt        = MIN_D;
                  res_status_nxt = ST_SAT;
                end else begin
                  acc_nxt = opnd_sx[DW-1:0];
                end
              end
              OP_END: begin
                halted_nxt    = 1'b1;
                res_ended_nxt = 1'b1;
              end
              OP_ADD, OP_SUB: begin
                if ($signed(sum_s) > $signed(MAX_A)) begin
                  acc_nxt        = MAX_D;
                  res_status_nxt = ST_SAT;
                end else if ($signed(sum_s) < $signed(MIN_A)) begin
                  acc_nxt        = MIN_D;
                  res_status_nxt = ST_SAT;
                end else begin
                  acc_nxt = sum_s[DW-1:0];
                end
              end
              OP_MUL: begin
                mcand_nxt  = sum_s[DW-1:0];
                mhi_nxt    = '0;
                mlo_nxt    = opnd_mag;
                neg_nxt    = acc_r[DW-1] ^ opnd_u[OPND_W-1];
                is_div_nxt = 1'b0;
                cnt_nxt    = CW'(OPND_W - 1);
                state_nxt  = S_MUL;
              end
              OP_DIV: begin
                if (opnd_u == '0) begin
                  res_status_nxt = ST_DIVZERO;
                end else begin
                  nq_nxt     = NW'(sum_s[DW-1:0]) << FRAC_BITS;
                  rem_nxt    = '0;
                  dvs_nxt    = opnd_mag;
                  neg_nxt    = acc_r[DW-1] ^ opnd_u[OPND_W-1];
                  is_div_nxt = 1'b1;
                  cnt_nxt    = CW'(NW - 1);
                  state_nxt  = S_DIV;
                end
              end
              default: begin
                res_status_nxt = ST_UNKNOWN;
              end
            endcase
          end
        end
      end
      // one shift-add step per operand bit
      S_MUL: begin
        mhi_nxt = mul_s[DW:1];
        mlo_nxt = {mul_s[0], mlo_r[OPND_W-1:1]};
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == '0) begin
          state_nxt = S_FIX;
        end
      end
      // one restoring quotient bit per cycle
      S_DIV: begin
        rem_nxt = alu_y[AW] ? alu_y[OPND_W-1:0] : div_r2[OPND_W-1:0];
        nq_nxt  = {nq_r[NW-2:0], alu_y[AW]};
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == '0) begin
          state_nxt = S_FIX;
        end
      end
      // apply sign and saturate
      S_FIX: begin
        if (fix_sat) begin
          acc_nxt        = neg_r ? MIN_D : MAX_D;
          res_status_nxt = ST_SAT;
        end else begin
          acc_nxt        = sum_s[DW-1:0];
          res_status_nxt = ST_OK;
        end
        res_ended_nxt = 1'b0;
        state_nxt     = S_FIN;
      end
      // hand the word to the result register
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_acc_nxt    = acc_sx[OPND_W-1:0];
          out_status_nxt = res_status_r;
          out_ended_nxt  = res_ended_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      acc_r       <= '0;
      halted_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      acc_r       <= acc_nxt;
      halted_r    <= halted_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    mcand_r      <= mcand_nxt;
    mhi_r        <= mhi_nxt;
    mlo_r        <= mlo_nxt;
    nq_r         <= nq_nxt;
    rem_r        <= rem_nxt;
    dvs_r        <= dvs_nxt;
    cnt_r        <= cnt_nxt;
    neg_r        <= neg_nxt;
    is_div_r     <= is_div_nxt;
    res_status_r <= res_status_nxt;
    res_ended_r  <= res_ended_nxt;
    out_acc_r    <= out_acc_nxt;
    out_status_r <= out_status_nxt;
    out_ended_r  <= out_ended_nxt;
  end

  // channel ports
  assign in_chan.ready      = (state_r == S_IDLE);
  assign out_chan.valid     = out_valid_r;
  assign out_chan.acc_value = out_acc_r;
  assign out_chan.status    = out_status_r;
  assign out_chan.ended     = out_ended_r;

  // once halted, only reset brings the block back
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |=> halted_r)
    else $error("halted flag dropped without reset");

  // a halted status is only reported after end
  a_halt_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.status == ST_HALTED) |-> halted_r)
    else $error("halted status while running");

  // the end word reports ok and leaves the block halted
  a_end_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.ended) |-> (out_chan.status == ST_OK && halted_r))
    else $error("end word with bad status or block not halted");

  // the accumulator holds while the shared unit iterates
  a_acc_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL || state_r == S_DIV) |=> $stable(acc_r))
    else $error("accumulator changed during multiply or divide");

endmodule

`default_nettype wire
